@@ src/i2cm_pkg.sv @@
// Shared types and constants of the I2C register access master.
package i2cm_pkg;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_SETUP = 4'd1,
        PH_START_HOLD  = 4'd2,
        PH_TX_LOW      = 4'd3,
        PH_TX_HIGH     = 4'd4,
        PH_ACK_LOW     = 4'd5,
        PH_ACK_HIGH    = 4'd6,
        PH_RS_LOW      = 4'd7,
        PH_RX_LOW      = 4'd8,
        PH_RX_HIGH     = 4'd9,
        PH_NACK_LOW    = 4'd10,
        PH_NACK_HIGH   = 4'd11,
        PH_STOP_LOW    = 4'd12,
        PH_STOP_HIGH   = 4'd13,
        PH_STOP_REL    = 4'd14,
        PH_FIN         = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        STG_ADDR  = 2'd0,
        STG_REG   = 2'd1,
        STG_DATA  = 2'd2,
        STG_RX    = 2'd3
    } t_stage;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [0:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [0:0] CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd21;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd250;
    localparam logic [3:0] BITS_PER_BYTE        = 4'd8;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_request;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       ack_error;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } t_result;

endpackage

@@ src/i2cm_seq.sv @@
// Bus sequencer: state registers and the single-step next-state and output logic.
module i2cm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  i2cm_pkg::t_request i_req,
    input  logic [6:0]        i_device_address,
    input  logic [7:0]        i_ack_timeout,
    output i2cm_pkg::t_result o_result
);
    import i2cm_pkg::*;

    t_phase     r_phase,      n_phase;
    t_stage     r_stage,      n_stage;
    logic [3:0] r_bit_count,  n_bit_count;
    logic [7:0] r_shift_reg,  n_shift_reg;
    logic [7:0] r_wait_count, n_wait_count;
    logic       r_is_read,    n_is_read;
    logic [7:0] r_held_reg,   n_held_reg;
    logic [7:0] r_held_data,  n_held_data;
    logic [7:0] r_rx_byte,    n_rx_byte;
    logic       r_error_flag, n_error_flag;

    logic       free_bus;
    logic [3:0] bit_inc;

    always_comb begin
        n_phase      = r_phase;
        n_stage      = r_stage;
        n_bit_count  = r_bit_count;
        n_shift_reg  = r_shift_reg;
        n_wait_count = r_wait_count;
        n_is_read    = r_is_read;
        n_held_reg   = r_held_reg;
        n_held_data  = r_held_data;
        n_rx_byte    = r_rx_byte;
        n_error_flag = r_error_flag;
        free_bus     = (r_phase == PH_IDLE) || (r_phase == PH_FIN);
        bit_inc      = r_bit_count + 4'd1;

        if (i_req.func == FUNC_TICK) begin
            case (r_phase)
                PH_IDLE: ;
                PH_START_SETUP: n_phase = PH_START_HOLD;
                PH_START_HOLD: begin
                    n_shift_reg = {i_device_address,
                                   (r_is_read && (r_stage == STG_DATA))};
                    n_bit_count = '0;
                    n_phase     = PH_TX_LOW;
                end
                PH_TX_LOW: n_phase = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    n_shift_reg = {r_shift_reg[6:0], 1'b0};
                    n_bit_count = bit_inc;
                    n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW: begin
                    n_wait_count = '0;
                    n_phase      = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    if (!i_req.sda_in) begin
                        case (r_stage)
                            STG_ADDR: begin
                                n_stage     = STG_REG;
                                n_shift_reg = r_held_reg;
                                n_bit_count = '0;
                                n_phase     = PH_TX_LOW;
                            end
                            STG_REG: begin
                                n_stage = STG_DATA;
                                if (r_is_read) begin
                                    n_phase = PH_RS_LOW;
                                end else begin
                                    n_shift_reg = r_held_data;
                                    n_bit_count = '0;
                                    n_phase     = PH_TX_LOW;
                                end
                            end
                            STG_DATA: begin
                                if (r_is_read) begin
                                    n_stage     = STG_RX;
                                    n_shift_reg = '0;
                                    n_bit_count = '0;
                                    n_phase     = PH_RX_LOW;
                                end else begin
                                    n_phase = PH_STOP_LOW;
                                end
                            end
                            default: n_phase = PH_STOP_LOW;
                        endcase
                    end else if (r_wait_count >= i_ack_timeout) begin
                        n_error_flag = 1'b1;
                        n_phase      = PH_STOP_LOW;
                    end else begin
                        n_wait_count = r_wait_count + 8'd1;
                    end
                end
                PH_RS_LOW: n_phase = PH_START_SETUP;
                PH_RX_LOW: n_phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    n_shift_reg = {r_shift_reg[6:0], i_req.sda_in};
                    n_bit_count = bit_inc;
                    n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RX_LOW;
                end
                PH_NACK_LOW: n_phase = PH_NACK_HIGH;
                PH_NACK_HIGH: begin
                    n_rx_byte = r_shift_reg;
                    n_phase   = PH_STOP_LOW;
                end
                PH_STOP_LOW:  n_phase = PH_STOP_HIGH;
                PH_STOP_HIGH: n_phase = PH_STOP_REL;
                PH_STOP_REL:  n_phase = PH_FIN;
                PH_FIN:       n_phase = PH_IDLE;
                default:      n_phase = PH_IDLE;
            endcase
        end else if ((i_req.func inside {FUNC_WRITE, FUNC_READ}) && free_bus) begin
            n_held_reg   = i_req.reg_addr;
            n_held_data  = i_req.write_data;
            n_is_read    = (i_req.func == FUNC_READ);
            n_error_flag = 1'b0;
            n_stage      = STG_ADDR;
            n_bit_count  = '0;
            n_wait_count = '0;
            n_phase      = PH_START_SETUP;
        end

        o_result.scl_level    = 1'b1;
        o_result.sda_pull_low = 1'b0;
        o_result.busy_res     = 1'b1;
        o_result.done_res     = 1'b0;
        o_result.ack_error    = 1'b0;
        o_result.read_byte    = n_rx_byte;
        case (n_phase)
            PH_IDLE: begin
                o_result.busy_res  = 1'b0;
                o_result.ack_error = n_error_flag;
            end
            PH_FIN: begin
                o_result.busy_res  = 1'b0;
                o_result.done_res  = 1'b1;
                o_result.ack_error = n_error_flag;
            end
            PH_START_SETUP: ;
            PH_START_HOLD: o_result.sda_pull_low = 1'b1;
            PH_TX_LOW: begin
                o_result.scl_level    = 1'b0;
                o_result.sda_pull_low = ~n_shift_reg[7];
            end
            PH_TX_HIGH: o_result.sda_pull_low = ~n_shift_reg[7];
            PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW, PH_NACK_LOW: o_result.scl_level = 1'b0;
            PH_ACK_HIGH, PH_RX_HIGH, PH_NACK_HIGH, PH_STOP_REL: ;
            PH_STOP_LOW: begin
                o_result.scl_level    = 1'b0;
                o_result.sda_pull_low = 1'b1;
            end
            PH_STOP_HIGH: o_result.sda_pull_low = 1'b1;
            default: o_result.busy_res = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_stage      <= STG_ADDR;
            r_bit_count  <= '0;
            r_shift_reg  <= '0;
            r_wait_count <= '0;
            r_is_read    <= 1'b0;
            r_held_reg   <= '0;
            r_held_data  <= '0;
            r_rx_byte    <= '0;
            r_error_flag <= 1'b0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_stage      <= n_stage;
            r_bit_count  <= n_bit_count;
            r_shift_reg  <= n_shift_reg;
            r_wait_count <= n_wait_count;
            r_is_read    <= n_is_read;
            r_held_reg   <= n_held_reg;
            r_held_data  <= n_held_data;
            r_rx_byte    <= n_rx_byte;
            r_error_flag <= n_error_flag;
        end
    end

endmodule

@@ src/i2c_master_register_access.sv @@
// Top level of the I2C register access master: request and result registers, configuration.
// Each request is a command (single-register write or read), a bus timing tick carrying the
// sampled SDA level or an unused function code, and produces exactly one result with the SCL
// and SDA drive levels and the transfer status. One request is taken every clock cycle while
// results are taken. A request accepted into the request register passes on to the result
// register, from which its result is presented. While a result waits to be taken, one further
// request is held in the request register and the request side then stalls until the result
// is taken. Commands arriving during a transfer are ignored. Configuration writes take effect
// at once and should only be made while no request is in flight.
module i2c_master_register_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // reg_addr[7:0], write_data[15:8], sda_in[16], zeros
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // scl_level[0], sda_pull_low[1], busy_res[2],
                                       // done_res[3], ack_error[4], read_byte[12:5], zeros
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import i2cm_pkg::*;

    logic       r_in_valid;
    t_request   r_in;
    logic       r_out_valid;
    t_result    r_out;
    logic [6:0] r_device_address;
    logic [7:0] r_ack_timeout;
    logic       fire;
    t_result    step_result;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    i2cm_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (fire),
        .i_req            (r_in),
        .i_device_address (r_device_address),
        .i_ack_timeout    (r_ack_timeout),
        .o_result         (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RESET;
            r_ack_timeout    <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                CFG_ACK_TIMEOUT:    r_ack_timeout    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func       <= s_axis_tuser;
            r_in.reg_addr   <= s_axis_tdata[7:0];
            r_in.write_data <= s_axis_tdata[15:8];
            r_in.sda_in     <= s_axis_tdata[16];
        end
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule

@@ tb/i2c_master_register_access_tb.sv @@
// Testbench of the I2C register access master: predicted bus levels and status checked per result.
module i2c_master_register_access_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          LATENCY_CYCLES = 4;
    localparam int          DRAIN_LIMIT    = 5000;
    localparam int          RANDOM_ITEMS   = 100;
    localparam int          NO_REFUSAL     = -1;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // Predicted state of the bus sequencer and its configuration.
    t_phase     bus_phase       = PH_IDLE;
    t_stage     byte_stage      = STG_ADDR;
    logic [3:0] bit_idx         = '0;
    logic [7:0] shifter         = '0;
    logic [7:0] ack_wait        = '0;
    logic [7:0] held_reg_addr   = '0;
    logic [7:0] held_write_data = '0;
    logic [7:0] last_read       = '0;
    logic       read_cmd        = 1'b0;
    logic       aborted         = 1'b0;
    logic [6:0] dev_addr        = DEVICE_ADDRESS_RESET;
    logic [7:0] ack_limit       = ACK_TIMEOUT_RESET;

    t_result    expected_results[$];
    t_result    seen_result;
    t_result    wanted_result;
    int         failures      = 0;
    int         sent_items    = 0;
    int         sink_hold_off = 0;
    int         sink_stall    = 0;
    bit         sender_idle   = 1'b1;
    bit         sink_idle     = 1'b1;

    i2c_master_register_access u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic load_shifter(input logic [7:0] value);
        shifter   = value;
        bit_idx   = '0;
        bus_phase = PH_TX_LOW;
    endtask

    task automatic step_master(input t_request req, output t_result res);
        logic bus_free;
        logic read_bit;
        bus_free = (bus_phase == PH_IDLE) || (bus_phase == PH_FIN);
        read_bit = (read_cmd && byte_stage == STG_DATA) ? 1'b1 : 1'b0;
        if (req.func == FUNC_TICK) begin
            case (bus_phase)
                PH_START_SETUP: bus_phase = PH_START_HOLD;
                PH_START_HOLD:  load_shifter({dev_addr, read_bit});
                PH_TX_LOW:      bus_phase = PH_TX_HIGH;
                PH_TX_HIGH: begin
                    shifter   = shifter << 1;
                    bit_idx   = bit_idx + 4'd1;
                    bus_phase = (bit_idx >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                end
                PH_ACK_LOW: begin
                    ack_wait  = '0;
                    bus_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    if (!req.sda_in) begin
                        if (byte_stage == STG_ADDR) begin
                            byte_stage = STG_REG;
                            load_shifter(held_reg_addr);
                        end else if (byte_stage == STG_REG) begin
                            byte_stage = STG_DATA;
                            if (read_cmd) bus_phase = PH_RS_LOW;
                            else load_shifter(held_write_data);
                        end else if (byte_stage == STG_DATA && read_cmd) begin
                            byte_stage = STG_RX;
                            shifter    = '0;
                            bit_idx    = '0;
                            bus_phase  = PH_RX_LOW;
                        end else begin
                            bus_phase = PH_STOP_LOW;
                        end
                    end else if (ack_wait >= ack_limit) begin
                        aborted   = 1'b1;
                        bus_phase = PH_STOP_LOW;
                    end else begin
                        ack_wait = ack_wait + 8'd1;
                    end
                end
                PH_RS_LOW: bus_phase = PH_START_SETUP;
                PH_RX_LOW: bus_phase = PH_RX_HIGH;
                PH_RX_HIGH: begin
                    shifter   = {shifter[6:0], req.sda_in};
                    bit_idx   = bit_idx + 4'd1;
                    bus_phase = (bit_idx >= BITS_PER_BYTE) ? PH_NACK_LOW : PH_RX_LOW;
                end
                PH_NACK_LOW: bus_phase = PH_NACK_HIGH;
                PH_NACK_HIGH: begin
                    last_read = shifter;
                    bus_phase = PH_STOP_LOW;
                end
                PH_STOP_LOW:  bus_phase = PH_STOP_HIGH;
                PH_STOP_HIGH: bus_phase = PH_STOP_REL;
                PH_STOP_REL:  bus_phase = PH_FIN;
                PH_FIN:       bus_phase = PH_IDLE;
                default:      bus_phase = PH_IDLE;
            endcase
        end else if ((req.func == FUNC_WRITE || req.func == FUNC_READ) && bus_free) begin
            held_reg_addr   = req.reg_addr;
            held_write_data = req.write_data;
            read_cmd        = (req.func == FUNC_READ);
            aborted         = 1'b0;
            byte_stage      = STG_ADDR;
            bit_idx         = '0;
            ack_wait        = '0;
            bus_phase       = PH_START_SETUP;
        end

        res           = '0;
        res.scl_level = 1'b1;
        res.busy_res  = 1'b1;
        res.read_byte = last_read;
        case (bus_phase)
            PH_IDLE: begin
                res.busy_res  = 1'b0;
                res.ack_error = aborted;
            end
            PH_FIN: begin
                res.busy_res  = 1'b0;
                res.done_res  = 1'b1;
                res.ack_error = aborted;
            end
            PH_START_HOLD: res.sda_pull_low = 1'b1;
            PH_TX_LOW: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = ~shifter[7];
            end
            PH_TX_HIGH: res.sda_pull_low = ~shifter[7];
            PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW, PH_NACK_LOW: res.scl_level = 1'b0;
            PH_STOP_LOW: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = 1'b1;
            end
            PH_STOP_HIGH: res.sda_pull_low = 1'b1;
            default: ;
        endcase
    endtask

    // Called in the time step of a rising edge; returns in the step of the accepting edge.
    task automatic send_request(input logic [1:0] func, input logic [7:0] reg_addr,
                                input logic [7:0] data, input logic sda);
        t_request req;
        t_result  res;
        int       gap;
        req.func       = func;
        req.reg_addr   = reg_addr;
        req.write_data = data;
        req.sda_in     = sda;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, sda, data, reg_addr};
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_master(req, res);
        expected_results.push_back(res);
        sent_items++;
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [0:0] index, input logic [7:0] value);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == CFG_DEVICE_ADDRESS) dev_addr = value[6:0];
        else ack_limit = value;
    endtask

    // A target that acknowledges after a short random delay, except on the refused byte.
    function automatic logic pick_sda(input int refuse);
        if (bus_phase == PH_ACK_HIGH) begin
            if (refuse == int'(byte_stage)) return 1'b1;
            return ($urandom_range(0, 3) == 0);
        end
        return 1'($urandom);
    endfunction

    task automatic run_transfer(input logic [1:0] func, input logic [7:0] reg_addr,
                                input logic [7:0] data, input int refuse, input bit noisy,
                                input bit stop_at_fin);
        send_request(func, reg_addr, data, 1'($urandom));
        while (bus_phase != PH_IDLE && !(stop_at_fin && bus_phase == PH_FIN)) begin
            if (noisy && $urandom_range(0, 15) == 0)
                send_request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                             1'($urandom));
            else
                send_request(FUNC_TICK, 8'($urandom), 8'($urandom), pick_sda(refuse));
        end
    endtask

    task automatic test_idle_inputs();
        send_request(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        send_request(FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
        send_request(FUNC_UNUSED, 8'hFF, 8'hFF, 1'b1);
        send_request(FUNC_UNUSED, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_write_transfers();
        run_transfer(FUNC_WRITE, 8'hFF, 8'h00, NO_REFUSAL, 1'b0, 1'b1);
        write_config(CFG_DEVICE_ADDRESS, 8'h80);
        run_transfer(FUNC_WRITE, 8'hA5, 8'h5A, NO_REFUSAL, 1'b1, 1'b0);
    endtask

    task automatic test_read_transfers();
        run_transfer(FUNC_READ, 8'hFF, 8'h00, NO_REFUSAL, 1'b0, 1'b1);
        write_config(CFG_DEVICE_ADDRESS, 8'h7F);
        run_transfer(FUNC_READ, 8'h81, 8'h7E, NO_REFUSAL, 1'b1, 1'b0);
    endtask

    task automatic test_ack_timeouts();
        write_config(CFG_ACK_TIMEOUT, 8'd1);
        run_transfer(FUNC_WRITE, 8'h12, 8'h34, int'(STG_ADDR), 1'b0, 1'b0);
        // The read address after the repeated start is refused, so the last byte read stays.
        run_transfer(FUNC_READ, 8'h56, 8'h00, int'(STG_DATA), 1'b0, 1'b0);
        write_config(CFG_ACK_TIMEOUT, 8'd0);
        run_transfer(FUNC_WRITE, 8'h9A, 8'hBC, int'(STG_REG), 1'b0, 1'b0);
        write_config(CFG_ACK_TIMEOUT, 8'd30);
        run_transfer(FUNC_READ, 8'hDE, 8'h00, int'(STG_REG), 1'b0, 1'b0);
        write_config(CFG_ACK_TIMEOUT, 8'd4);
    endtask

    task automatic test_receiver_hold_off();
        sender_idle   = 1'b0;
        sink_hold_off = HOLD_OFF_CYCLES;
        run_transfer(FUNC_READ, 8'h3C, 8'hC3, NO_REFUSAL, 1'b0, 1'b0);
        wait_for_results();
        sender_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         stop_at;
        int         roll;
        int         refuse;
        logic [0:0] index;
        logic [7:0] value;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                index = 1'($urandom);
                if (index == CFG_ACK_TIMEOUT && $urandom_range(0, 3) != 0)
                    value = 8'($urandom_range(0, 10));
                else
                    value = 8'($urandom);
                write_config(index, value);
            end else if (roll < 18) begin
                repeat ($urandom_range(1, 4))
                    send_request(2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                refuse = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : NO_REFUSAL;
                run_transfer($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE, 8'($urandom),
                             8'($urandom), refuse, 1'($urandom), 1'($urandom));
            end
        end
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (sink_hold_off > 0) begin
            sink_hold_off--;
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (sink_idle && $urandom_range(0, 7) == 0) sink_stall = pick_gap() + 1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = m_axis_tdata[12:0];
            if (expected_results.size() == 0) begin
                $error("Result %h arrived with no request outstanding", m_axis_tdata);
                failures++;
            end else begin
                wanted_result = expected_results.pop_front();
                check_field("scl_level", 32'(wanted_result.scl_level),
                            32'(seen_result.scl_level));
                check_field("sda_pull_low", 32'(wanted_result.sda_pull_low),
                            32'(seen_result.sda_pull_low));
                check_field("busy_res", 32'(wanted_result.busy_res),
                            32'(seen_result.busy_res));
                check_field("done_res", 32'(wanted_result.done_res),
                            32'(seen_result.done_res));
                check_field("ack_error", 32'(wanted_result.ack_error),
                            32'(seen_result.ack_error));
                check_field("read_byte", 32'(wanted_result.read_byte),
                            32'(seen_result.read_byte));
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_inputs();
        test_write_transfers();
        test_read_transfers();
        test_ack_timeouts();
        test_receiver_hold_off();
        test_random_traffic();
        wait_for_results();
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
